// ----- sv/sirt_pkg.sv -----
// sirt_pkg: shared types and constants for the signed integer to radix text block
// holds register reset values, register indexes, controller/datapath command and status
// structs, and the radix clamp and alphabet lookup helpers
package sirt_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 64;
    localparam int POS_W      = $clog2(MAX_DIGITS);
    localparam int STEP_BITS  = 8;
    localparam int STEP_W     = $clog2(STEP_BITS);
    localparam int ALPHA_W    = 64;
    localparam int REG_IDX_W  = 2;
    localparam int PADDR_W    = 5;

    localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN        = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX        = 5'd16;
    localparam logic [ALPHA_W-1:0] ALPHA_LOW_RESET  = 64'h3736353433323130;
    localparam logic [ALPHA_W-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RADIX      = 2'd0,
        REG_ALPHA_LOW  = 2'd1,
        REG_ALPHA_HIGH = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic load;      // capture a new value
        logic div_step;  // run STEP_BITS steps of the long division
        logic store;     // write the finished digit
        logic rd;        // read the digit at the emit pointer
        logic out_load;  // move the character into the output register
        logic pos_dec;   // step the emit pointer down
    } cmd_t;

    typedef struct packed {
        logic step_last;
        logic mag_zero;
        logic cnt_full;
        logic pos_zero;
        logic out_fire;
    } status_t;

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        r = raw;
        if (raw < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(
        input logic [ALPHA_W-1:0] alo,
        input logic [ALPHA_W-1:0] ahi,
        input logic [DIGIT_W-1:0] d
    );
        logic [ALPHA_W-1:0] word;
        word = d[DIGIT_W-1] ? ahi : alo;
        return word[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

// ----- sv/sirt_ram.sv -----
// sirt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module sirt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sirt_ctrl.sv -----
// sirt_ctrl: sequencer for divide, store and emit phases
// depends on sirt_pkg for the command and status structs
module sirt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sirt_pkg::status_t st,
    output sirt_pkg::cmd_t    cmd
);
    import sirt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (st.step_last) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                // quotient exhausted or store full: start emitting from the top digit
                if (st.mag_zero || st.cnt_full) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND: begin
                if (st.out_fire) begin
                    if (st.pos_zero) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.pos_dec = 1'b1;
                        state_next  = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/sirt_dp.sv -----
// sirt_dp: magnitude register, shared long-division unit, digit store and output register
// depends on sirt_pkg and sirt_ram
module sirt_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sirt_pkg::cmd_t                      cmd,
    output sirt_pkg::status_t                   st,
    input  logic [sirt_pkg::VALUE_W-1:0]        in_value,
    input  logic [sirt_pkg::RADIX_W-1:0]        radix_raw,
    input  logic [sirt_pkg::ALPHA_W-1:0]        alpha_low,
    input  logic [sirt_pkg::ALPHA_W-1:0]        alpha_high,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sirt_pkg::CHAR_W-1:0]         m_char,
    output logic                                m_lead_minus,
    output logic                                m_last
);
    import sirt_pkg::*;

    logic [VALUE_W-1:0] mag_reg,   mag_next;
    logic [DIGIT_W-1:0] rem_reg,   rem_next;
    logic [STEP_W-1:0]  step_reg,  step_next;
    logic [POS_W-1:0]   cnt_reg,   cnt_next;
    logic [POS_W-1:0]   pos_reg,   pos_next;
    logic               neg_reg,   neg_next;
    logic               first_reg, first_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg,  char_next;
    logic               minus_reg, minus_next;
    logic               last_reg,  last_next;

    logic [RADIX_W-1:0]   radix;
    logic [VALUE_W-1:0]   div_mag;
    logic [DIGIT_W-1:0]   div_rem;
    logic [STEP_BITS-1:0] div_q;
    logic [RADIX_W-1:0]   trial;
    logic [DIGIT_W-1:0]   rd_digit;
    logic                 out_fire;

    assign radix    = clamp_radix(radix_raw);
    assign out_fire = valid_reg && m_tready;

    // STEP_BITS restoring division steps: top bits leave, quotient bits enter at the bottom
    always_comb begin
        div_rem = rem_reg;
        div_q   = '0;
        trial   = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {div_rem, mag_reg[VALUE_W-1-i]};
            if (trial >= radix) begin
                trial                = trial - radix;
                div_q[STEP_BITS-1-i] = 1'b1;
            end
            div_rem = trial[DIGIT_W-1:0];
        end
        div_mag = {mag_reg[VALUE_W-STEP_BITS-1:0], div_q};
    end

    sirt_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(MAX_DIGITS)
    ) u_digits (
        .aclk (aclk),
        .we   (cmd.store),
        .waddr(cnt_reg),
        .wdata(rem_reg),
        .re   (cmd.rd),
        .raddr(pos_reg),
        .rdata(rd_digit)
    );

    always_comb begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        neg_next   = neg_reg;
        first_next = first_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        minus_next = minus_reg;
        last_next  = last_reg;

        if (cmd.load) begin
            neg_next   = in_value[VALUE_W-1];
            // two's complement negation keeps the most negative value exact
            mag_next   = in_value[VALUE_W-1] ? ('0 - in_value) : in_value;
            rem_next   = '0;
            step_next  = '0;
            cnt_next   = '0;
            first_next = 1'b1;
        end
        if (cmd.div_step) begin
            mag_next  = div_mag;
            rem_next  = div_rem;
            step_next = step_reg + 1'b1;
        end
        if (cmd.store) begin
            rem_next = '0;
            pos_next = cnt_reg;
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.pos_dec) begin
            pos_next = pos_reg - 1'b1;
        end
        if (out_fire) begin
            valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            valid_next = 1'b1;
            char_next  = digit_char(alpha_low, alpha_high, rd_digit);
            minus_next = neg_reg && first_reg;
            last_next  = (pos_reg == '0);
            first_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg   <= '0;
            step_reg  <= '0;
            cnt_reg   <= '0;
            pos_reg   <= '0;
            first_reg <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            mag_reg   <= mag_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            pos_reg   <= pos_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
        rem_reg   <= rem_next;
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        minus_reg <= minus_next;
        last_reg  <= last_next;
    end

    assign st.step_last = (step_reg == STEP_W'(STEP_BITS - 1));
    assign st.mag_zero  = (mag_reg == '0);
    assign st.cnt_full  = (cnt_reg == POS_W'(MAX_DIGITS - 1));
    assign st.pos_zero  = (pos_reg == '0);
    assign st.out_fire  = out_fire;

    assign m_tvalid     = valid_reg;
    assign m_char       = char_reg;
    assign m_lead_minus = minus_reg;
    assign m_last       = last_reg;

endmodule

// ----- sv/signed_integer_to_radix_text_top.sv -----
// signed_integer_to_radix_text_top: configuration registers and the controller/datapath pair
// depends on sirt_pkg, sirt_ctrl, sirt_dp (and sirt_ram below it)
//
//  port group   direction  word contents
//  s_*          in         s_tdata[63:0] = value (signed)
//  m_*          out        m_tdata[7:0] = character, m_tuser = lead_minus, m_tlast = last
//  apb          in/out     0x00 radix, 0x08 alphabet_low, 0x10 alphabet_high
//
// for each digit of a word, the shared 8-bit-per-cycle divider runs and then the store state
// writes the digit; emitting it goes through the registered read of the digit RAM and the
// output register
// one word at a time: s_tready is high only between words
// reset (aresetn low, synchronous) returns to idle and restores the register defaults
// a stalled m_tready holds the current character and the whole block
module signed_integer_to_radix_text_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] character
    output logic        m_tuser,   // [0] lead_minus
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sirt_pkg::*;

    logic [RADIX_W-1:0] radix_reg;
    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;
    reg_idx_t           reg_idx;
    logic               wr_en;
    cmd_t               cmd;
    status_t            st;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:PADDR_W-REG_IDX_W]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg      <= RADIX_RESET;
            alpha_low_reg  <= ALPHA_LOW_RESET;
            alpha_high_reg <= ALPHA_HIGH_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_RADIX:      radix_reg      <= pwdata[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RADIX:      prdata = {{(64-RADIX_W){1'b0}}, radix_reg};
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            default:        prdata = '0;
        endcase
    end

    sirt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .st      (st),
        .cmd     (cmd)
    );

    sirt_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st          (st),
        .in_value    (s_tdata),
        .radix_raw   (radix_reg),
        .alpha_low   (alpha_low_reg),
        .alpha_high  (alpha_high_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_char      (m_tdata),
        .m_lead_minus(m_tuser),
        .m_last      (m_tlast)
    );

endmodule

// ----- sv/sirt_checker.sv -----
// sirt_checker: port-level assertions for signed_integer_to_radix_text_top
// bound to the top level below; no package dependency
module sirt_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // input side closed while a word is being emitted
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while output valid");

    // the last character returns the block to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("block not idle after last character");

    // no result can appear right after a value is taken
    a_accept_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid && !s_tready)
        else $error("result or ready right after accept");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not idle after reset");

endmodule

bind signed_integer_to_radix_text_top sirt_checker u_sirt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
);
